### design/assert_macros.svh
// assertion macros used by the design files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

### design/hrd_pkg.sv
// package for the http response deframer: types, codes and helpers
// no dependencies
package hrd_pkg;

   localparam int LENGTH_BITS = 32;
   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

   localparam logic [2:0] PH_STATUS = 3'd0;
   localparam logic [2:0] PH_HEADERS = 3'd1;
   localparam logic [2:0] PH_SIZE = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_CHUNK_END = 3'd4;
   localparam logic [2:0] PH_TRAILER = 3'd5;
   localparam logic [2:0] PH_PLAIN = 3'd6;
   localparam logic [2:0] PH_DONE = 3'd7;

   localparam logic [2:0] NS_LEAD = 3'd0;
   localparam logic [2:0] NS_POS_SIGN = 3'd1;
   localparam logic [2:0] NS_NEG_SIGN = 3'd2;
   localparam logic [2:0] NS_POS_DIG = 3'd3;
   localparam logic [2:0] NS_NEG_DIG = 3'd4;
   localparam logic [2:0] NS_POS_END = 3'd5;
   localparam logic [2:0] NS_NEG_END = 3'd6;
   localparam logic [2:0] NS_BAD = 3'd7;

   localparam logic [1:0] OC_RUNNING = 2'd0;
   localparam logic [1:0] OC_COMPLETE = 2'd1;
   localparam logic [1:0] OC_EARLY_CLOSE = 2'd2;
   localparam logic [1:0] OC_MALFORMED = 2'd3;

   localparam logic [4:0] TE_LEN = 5'd17;
   localparam logic [4:0] CL_LEN = 5'd14;
   localparam logic [2:0] WORD_LEN = 3'd7;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic conn_closed;
   } req_type;

   typedef struct packed {
      logic body_valid;
      logic [7:0] body_byte;
      logic [9:0] resp_code;
      logic [1:0] outcome;
   } rsp_type;

   function automatic logic [7:0] te_char(input logic [4:0] i);
      case (i)
         5'd0: te_char = "t";
         5'd1: te_char = "r";
         5'd2: te_char = "a";
         5'd3: te_char = "n";
         5'd4: te_char = "s";
         5'd5: te_char = "f";
         5'd6: te_char = "e";
         5'd7: te_char = "r";
         5'd8: te_char = "-";
         5'd9: te_char = "e";
         5'd10: te_char = "n";
         5'd11: te_char = "c";
         5'd12: te_char = "o";
         5'd13: te_char = "d";
         5'd14: te_char = "i";
         5'd15: te_char = "n";
         5'd16: te_char = "g";
         default: te_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] cl_char(input logic [4:0] i);
      case (i)
         5'd0: cl_char = "c";
         5'd1: cl_char = "o";
         5'd2: cl_char = "n";
         5'd3: cl_char = "t";
         5'd4: cl_char = "e";
         5'd5: cl_char = "n";
         5'd6: cl_char = "t";
         5'd7: cl_char = "-";
         5'd8: cl_char = "l";
         5'd9: cl_char = "e";
         5'd10: cl_char = "n";
         5'd11: cl_char = "g";
         5'd12: cl_char = "t";
         5'd13: cl_char = "h";
         default: cl_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] word_char(input logic [2:0] i);
      case (i)
         3'd0: word_char = "c";
         3'd1: word_char = "h";
         3'd2: word_char = "u";
         3'd3: word_char = "n";
         3'd4: word_char = "k";
         3'd5: word_char = "e";
         3'd6: word_char = "d";
         default: word_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      to_lower = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

endpackage

### design/hrd_stream_if.sv
// valid/ready channel interface carrying one payload item
// no dependencies
interface hrd_stream_if #(parameter type payload_type = logic);
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### design/http_response_deframer.sv
// http/1.1 response deframer: status, header scan and body decode
// uses hrd_pkg, hrd_stream_if and assert_macros.svh
//
// req carries one received byte per item, or a connection-closed marker.
// rsp carries one item per body byte, and one item on the step that ends
// the response (complete, early close or malformed number).
// every input item is processed by combinational logic between the parser
// state and the result register; a result appears on rsp in the cycle after
// its input item is accepted.
// throughput is one item per clock while rsp is not stalled; the single
// result register is the only buffer.
// when rsp is stalled with a result pending, req is held off until the
// result is taken, unless that result is taken in the same cycle.
// reset returns the parser to the status line and drops any pending result.
// after the response ends, further items are accepted and give no result
// until reset.
`include "assert_macros.svh"
module http_response_deframer (
   input logic clock,
   input logic reset,
   hrd_stream_if.sink req,
   hrd_stream_if.source rsp
);

   localparam int LB = hrd_pkg::LENGTH_BITS;

   logic [2:0] phase_ff, phase_in;
   logic after_return_ff, after_return_in;
   logic line_empty_ff, line_empty_in;
   logic seen_ff, seen_in;
   logic [4:0] key_pos_ff, key_pos_in;
   logic [1:0] key_match_ff, key_match_in;
   logic [2:0] word_pos_ff, word_pos_in;
   logic chunked_ff, chunked_in;
   logic length_known_ff, length_known_in;
   logic [LB-1:0] acc_ff, acc_in;
   logic [2:0] nflags_ff, nflags_in;
   logic [LB-1:0] decl_len_ff, decl_len_in;
   logic [LB-1:0] remain_ff, remain_in;
   logic [9:0] code_ff, code_in;
   logic out_valid_ff;
   hrd_pkg::rsp_type out_ff, out_in;
   logic emit;

   logic accept;
   assign req.ready = !out_valid_ff || rsp.ready;
   assign accept = req.valid && req.ready;
   assign rsp.valid = out_valid_ff;
   assign rsp.data = out_ff;

   // number feed helper signals
   logic [7:0] c, lc;
   logic is_ws, is_dec, is_hex;
   logic [3:0] dval;
   logic [LB+3:0] mul10, mul16;
   logic [LB-1:0] acc_step;
   logic acc_sat;

   assign c = req.data.rx_byte;
   assign lc = hrd_pkg::to_lower(c);
   assign is_ws = (c == " ") || (c >= 8'd9 && c <= 8'd13);
   assign is_dec = c >= "0" && c <= "9";
   assign is_hex = lc >= "a" && lc <= "f";

   logic num_base16;
   logic num_digit;
   always_comb begin
      num_digit = is_dec || (num_base16 && is_hex);
      dval = is_dec ? 4'(c - "0") : 4'(lc - "a" + 8'd10);
      mul10 = {4'd0, acc_ff} * (LB+4)'(10) + (LB+4)'(dval);
      mul16 = {acc_ff, 4'd0} + (LB+4)'(dval);
      acc_sat = num_base16 ? (mul16[LB+3:LB] != 4'd0) : (mul10[LB+3:LB] != 4'd0);
      acc_step = acc_sat ? hrd_pkg::LEN_MAX : (num_base16 ? mul16[LB-1:0] : mul10[LB-1:0]);
   end

   logic num_digits, num_neg;
   assign num_digits = nflags_ff >= hrd_pkg::NS_POS_DIG && nflags_ff <= hrd_pkg::NS_NEG_END;
   assign num_neg = nflags_ff == hrd_pkg::NS_NEG_DIG || nflags_ff == hrd_pkg::NS_NEG_END;

   logic [LB-1:0] remain_dec;
   assign remain_dec = remain_ff - LB'(1);

   always_comb begin
      logic [1:0] oc;
      logic do_feed;
      logic prefix_ok;
      logic [1:0] km;
      oc = hrd_pkg::OC_RUNNING;
      do_feed = 1'b0;
      prefix_ok = 1'b0;
      km = key_match_ff;
      num_base16 = phase_ff == hrd_pkg::PH_SIZE;
      phase_in = phase_ff;
      after_return_in = after_return_ff;
      line_empty_in = line_empty_ff;
      seen_in = seen_ff;
      key_pos_in = key_pos_ff;
      key_match_in = key_match_ff;
      word_pos_in = word_pos_ff;
      chunked_in = chunked_ff;
      length_known_in = length_known_ff;
      acc_in = acc_ff;
      nflags_in = nflags_ff;
      decl_len_in = decl_len_ff;
      remain_in = remain_ff;
      code_in = code_ff;
      emit = 1'b0;
      out_in = '0;
      if (phase_ff == hrd_pkg::PH_DONE) begin
      end else if (req.data.conn_closed) begin
         emit = 1'b1;
         out_in.outcome = (phase_ff == hrd_pkg::PH_STATUS) ? hrd_pkg::OC_EARLY_CLOSE
            : hrd_pkg::OC_COMPLETE;
      end else if (after_return_ff) begin
         after_return_in = 1'b0;
      end else if (phase_ff == hrd_pkg::PH_DATA) begin
         remain_in = remain_dec;
         if (remain_dec == '0) phase_in = hrd_pkg::PH_CHUNK_END;
         emit = 1'b1;
         out_in.body_valid = 1'b1;
         out_in.body_byte = c;
      end else if (phase_ff == hrd_pkg::PH_PLAIN) begin
         emit = 1'b1;
         out_in.body_valid = 1'b1;
         out_in.body_byte = c;
         if (length_known_ff) begin
            remain_in = remain_dec;
            if (remain_dec == '0) out_in.outcome = hrd_pkg::OC_COMPLETE;
         end
      end else if (c == 8'h0d) begin
         case (phase_ff)
            hrd_pkg::PH_STATUS: begin
               if (seen_ff) begin
                  if (!num_digits) oc = hrd_pkg::OC_MALFORMED;
                  else code_in = num_neg ? 10'd0
                     : (acc_ff > LB'(999) ? 10'd999 : acc_ff[9:0]);
               end
               if (oc == hrd_pkg::OC_RUNNING) phase_in = hrd_pkg::PH_HEADERS;
            end
            hrd_pkg::PH_HEADERS: begin
               if (line_empty_ff) begin
                  if (chunked_ff) phase_in = hrd_pkg::PH_SIZE;
                  else if (length_known_ff && decl_len_ff == '0) oc = hrd_pkg::OC_COMPLETE;
                  else begin
                     if (length_known_ff) remain_in = decl_len_ff;
                     phase_in = hrd_pkg::PH_PLAIN;
                  end
               end else if (seen_ff) begin
                  if (key_match_ff[0]) chunked_in = word_pos_ff == hrd_pkg::WORD_LEN;
                  if (key_match_ff[1]) begin
                     if (!num_digits) oc = hrd_pkg::OC_MALFORMED;
                     else if (num_neg && acc_ff != '0) length_known_in = 1'b0;
                     else begin
                        length_known_in = 1'b1;
                        decl_len_in = acc_ff;
                     end
                  end
               end
            end
            hrd_pkg::PH_SIZE: begin
               if (!line_empty_ff) begin
                  if (!num_digits) oc = hrd_pkg::OC_MALFORMED;
                  else begin
                     remain_in = (num_neg && acc_ff != '0) ? hrd_pkg::LEN_MAX : acc_ff;
                     phase_in = (remain_in == '0) ? hrd_pkg::PH_TRAILER : hrd_pkg::PH_DATA;
                  end
               end
            end
            hrd_pkg::PH_CHUNK_END: phase_in = hrd_pkg::PH_SIZE;
            hrd_pkg::PH_TRAILER: oc = hrd_pkg::OC_COMPLETE;
            default: ;
         endcase
         after_return_in = 1'b1;
         line_empty_in = 1'b1;
         seen_in = 1'b0;
         key_pos_in = '0;
         key_match_in = 2'b11;
         word_pos_in = '0;
         acc_in = '0;
         nflags_in = hrd_pkg::NS_LEAD;
         if (oc != hrd_pkg::OC_RUNNING) begin
            emit = 1'b1;
            out_in.outcome = oc;
         end
      end else begin
         case (phase_ff)
            hrd_pkg::PH_STATUS: begin
               line_empty_in = 1'b0;
               if (!seen_ff) begin
                  if (c == " ") seen_in = 1'b1;
               end else do_feed = 1'b1;
            end
            hrd_pkg::PH_HEADERS: begin
               line_empty_in = 1'b0;
               if (!seen_ff) begin
                  if (c == ":") begin
                     seen_in = 1'b1;
                     if (key_pos_ff != hrd_pkg::TE_LEN) km[0] = 1'b0;
                     if (key_pos_ff != hrd_pkg::CL_LEN) km[1] = 1'b0;
                  end else begin
                     if (key_pos_ff >= hrd_pkg::TE_LEN || hrd_pkg::te_char(key_pos_ff) != lc)
                        km[0] = 1'b0;
                     if (key_pos_ff >= hrd_pkg::CL_LEN || hrd_pkg::cl_char(key_pos_ff) != lc)
                        km[1] = 1'b0;
                     if (key_pos_ff != 5'd31) key_pos_in = key_pos_ff + 5'd1;
                  end
                  key_match_in = km;
               end else begin
                  do_feed = 1'b1;
                  if (word_pos_ff < hrd_pkg::WORD_LEN) begin
                     if (lc == hrd_pkg::word_char(word_pos_ff)) word_pos_in = word_pos_ff + 3'd1;
                     else word_pos_in = (lc == "c") ? 3'd1 : 3'd0;
                  end
               end
            end
            hrd_pkg::PH_SIZE: begin
               if (word_pos_ff == '0) begin
                  do_feed = 1'b1;
                  if (c == ";") word_pos_in = 3'd1;
                  else line_empty_in = 1'b0;
               end
            end
            default: ;
         endcase
         if (do_feed) begin
            case (nflags_ff)
               hrd_pkg::NS_LEAD, hrd_pkg::NS_POS_SIGN, hrd_pkg::NS_NEG_SIGN: begin
                  if (nflags_ff == hrd_pkg::NS_LEAD && is_ws) begin
                  end else if (nflags_ff == hrd_pkg::NS_LEAD && c == "+") begin
                     nflags_in = hrd_pkg::NS_POS_SIGN;
                  end else if (nflags_ff == hrd_pkg::NS_LEAD && c == "-") begin
                     nflags_in = hrd_pkg::NS_NEG_SIGN;
                  end else if (!num_digit) begin
                     nflags_in = hrd_pkg::NS_BAD;
                  end else begin
                     acc_in = LB'(dval);
                     nflags_in = (nflags_ff == hrd_pkg::NS_NEG_SIGN) ? hrd_pkg::NS_NEG_DIG
                        : hrd_pkg::NS_POS_DIG;
                     if (num_base16) seen_in = dval == 4'd0;
                  end
               end
               hrd_pkg::NS_POS_DIG, hrd_pkg::NS_NEG_DIG: begin
                  if (num_base16) begin
                     prefix_ok = seen_ff;
                     seen_in = 1'b0;
                  end
                  if (prefix_ok && lc == "x") begin
                  end else if (!num_digit) begin
                     nflags_in = (nflags_ff == hrd_pkg::NS_NEG_DIG) ? hrd_pkg::NS_NEG_END
                        : hrd_pkg::NS_POS_END;
                  end else acc_in = acc_step;
               end
               default: ;
            endcase
         end
      end
      out_in.resp_code = code_in;
      if (emit && out_in.outcome != hrd_pkg::OC_RUNNING) phase_in = hrd_pkg::PH_DONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hrd_pkg::PH_STATUS;
         after_return_ff <= 1'b0;
         line_empty_ff <= 1'b1;
         seen_ff <= 1'b0;
         key_pos_ff <= '0;
         key_match_ff <= 2'b11;
         word_pos_ff <= '0;
         chunked_ff <= 1'b0;
         length_known_ff <= 1'b0;
         acc_ff <= '0;
         nflags_ff <= hrd_pkg::NS_LEAD;
         decl_len_ff <= '0;
         remain_ff <= '0;
         code_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            after_return_ff <= after_return_in;
            line_empty_ff <= line_empty_in;
            seen_ff <= seen_in;
            key_pos_ff <= key_pos_in;
            key_match_ff <= key_match_in;
            word_pos_ff <= word_pos_in;
            chunked_ff <= chunked_in;
            length_known_ff <= length_known_in;
            acc_ff <= acc_in;
            nflags_ff <= nflags_in;
            decl_len_ff <= decl_len_in;
            remain_ff <= remain_in;
            code_ff <= code_in;
         end
         if (accept) out_valid_ff <= emit;
         else if (rsp.ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) out_ff <= out_in;
   end

   `ASSERT_IMPLIES(a_stall_blocks, clock, reset, out_valid_ff && !rsp.ready, !req.ready)
   `ASSERT_NEXT(a_done_silent, clock, reset, phase_ff == hrd_pkg::PH_DONE && accept, !out_valid_ff)
   `ASSERT_IMPLIES(a_done_sticky, clock, reset, phase_ff == hrd_pkg::PH_DONE, phase_in == hrd_pkg::PH_DONE)
   `ASSERT_IMPLIES(a_code_range, clock, reset, 1'b1, code_ff <= 10'd999)

endmodule
